>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is low.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold whenever the guard is true.
`define ASSERT_WHEN(label, clk, rst_n, guard, cond, msg) \
    `ASSERT_ON_CLK(label, clk, rst_n, (guard) |-> (cond), msg)

`endif

>>> src/sstk_pkg.sv
`default_nettype none

package sstk_pkg;

    // Stack geometry
    localparam int DEPTH    = 8;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int RESULT_W = 35;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    typedef logic [AW-1:0]              t_addr;
    typedef logic [CW-1:0]              t_fill;
    typedef logic signed [WORD_W-1:0]   t_word;
    typedef logic signed [RESULT_W-1:0] t_result;
    typedef logic [CMD_W-1:0]           t_cmd;
    typedef logic [STATUS_W-1:0]        t_status;

    // Command codes
    localparam t_cmd CMD_PUSH = 3'd0;
    localparam t_cmd CMD_POP  = 3'd1;
    localparam t_cmd CMD_PEEK = 3'd2;
    localparam t_cmd CMD_SUM  = 3'd3;
    localparam t_cmd CMD_MIN  = 3'd4;
    localparam t_cmd CMD_MAX  = 3'd5;

    // Status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_OVER  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // Output register source select
    typedef logic [1:0] t_osel;
    localparam t_osel OSEL_ZERO  = 2'd0;
    localparam t_osel OSEL_NEG1  = 2'd1;
    localparam t_osel OSEL_RDATA = 2'd2;
    localparam t_osel OSEL_ACC   = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic    ram_we;
        t_addr   ram_addr;
        logic    acc_en;
        logic    acc_first;
        t_cmd    op;
        logic    out_load;
        t_osel   out_sel;
        t_status out_status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> src/sstk_ram.sv
`default_nettype none

// Single-port RAM, registered read
module sstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/sstk_ctrl.sv
`default_nettype none

module sstk_ctrl import sstk_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_cmd     i_command,
    input  wire logic     i_out_stall,
    input  wire t_dp_stat i_stat,
    output logic          o_in_stall,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0] r_state, n_state;
    t_fill      r_fill,  n_fill;
    t_addr      r_idx,   n_idx;
    t_cmd       r_op,    n_op;

    logic    stall;
    logic    accept;
    logic    empty;
    logic    full;
    logic    last;
    t_fill   fill_m1;
    t_dp_cmd cmd;

    // Handshake and fill flags
    assign stall   = (r_state != S_IDLE) || (i_stat.out_valid && i_out_stall);
    assign accept  = i_in_valid && !stall;
    assign empty   = (r_fill == '0);
    assign full    = (r_fill == CW'(DEPTH));
    assign fill_m1 = r_fill - CW'(1);
    assign last    = (CW'(r_idx) == fill_m1);

    // Next state and datapath commands
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_idx          = r_idx;
        n_op           = r_op;
        cmd            = '0;
        cmd.op         = r_op;
        cmd.out_sel    = OSEL_ZERO;
        cmd.out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        CMD_PUSH: begin
                            cmd.out_load = 1'b1;
                            if (full) begin
                                cmd.out_status = ST_OVER;
                            end else begin
                                cmd.ram_we   = 1'b1;
                                cmd.ram_addr = r_fill[AW-1:0];
                                n_fill       = r_fill + CW'(1);
                            end
                        end
                        CMD_POP: begin
                            if (empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.ram_addr = fill_m1[AW-1:0];
                                n_fill       = fill_m1;
                                n_state      = S_READ;
                            end
                        end
                        CMD_PEEK: begin
                            if (empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_sel    = OSEL_NEG1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.ram_addr = fill_m1[AW-1:0];
                                n_state      = S_READ;
                            end
                        end
                        CMD_SUM, CMD_MIN, CMD_MAX: begin
                            if (empty) begin
                                cmd.out_load   = 1'b1;
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.ram_addr = '0;
                                n_idx        = '0;
                                n_op         = i_command;
                                n_state      = S_SCAN;
                            end
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // top entry is on the RAM output
                cmd.out_load = 1'b1;
                cmd.out_sel  = OSEL_RDATA;
                n_state      = S_IDLE;
            end
            S_SCAN: begin
                // one entry per cycle, next address issued ahead
                cmd.acc_en    = 1'b1;
                cmd.acc_first = (r_idx == '0);
                cmd.ram_addr  = r_idx + AW'(1);
                if (last) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_ACC;
                    n_state      = S_IDLE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
            r_op    <= CMD_SUM;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_op    <= n_op;
        end
    end

    assign o_in_stall = stall;
    assign o_cmd      = cmd;

endmodule

`default_nettype wire

>>> src/sstk_dp.sv
`default_nettype none

module sstk_dp import sstk_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    input  wire t_word   i_value,
    input  wire logic    i_out_stall,
    output t_dp_stat     o_stat,
    output logic         o_out_valid,
    output t_result      o_result,
    output t_status      o_status
);

    logic [WORD_W-1:0] rdata_raw;
    t_word             rdata;
    t_result           ext;
    t_result           r_acc, n_acc;
    t_result           r_result, n_result;
    t_status           r_status;
    logic              r_out_valid;

    // Entry storage
    sstk_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (i_cmd.ram_addr),
        .i_wdata (i_value),
        .o_rdata (rdata_raw)
    );

    assign rdata = t_word'(rdata_raw);
    assign ext   = RESULT_W'(rdata);

    // Accumulate: sum wraps at result width, min/max by signed compare
    always_comb begin
        if (i_cmd.acc_first) begin
            n_acc = ext;
        end else begin
            case (i_cmd.op)
                CMD_MIN: n_acc = (ext < r_acc) ? ext : r_acc;
                CMD_MAX: n_acc = (ext > r_acc) ? ext : r_acc;
                default: n_acc = r_acc + ext;
            endcase
        end
    end

    // Result source
    always_comb begin
        case (i_cmd.out_sel)
            OSEL_NEG1:  n_result = t_result'(-1);
            OSEL_RDATA: n_result = ext;
            OSEL_ACC:   n_result = n_acc;
            default:    n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_en) begin
            r_acc <= n_acc;
        end
        if (i_cmd.out_load) begin
            r_result <= n_result;
            r_status <= i_cmd.out_status;
        end
    end

    // Output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_result         = r_result;
    assign o_status         = r_status;

endmodule

`default_nettype wire

>>> src/stack_with_sum_min_max_core.sv
// Push, unused codes and empty-stack commands load the output register on accept;
// pop and peek go through the registered RAM read first; sum, min and max scan every entry.
// Throughput: one command in flight; the next beat is accepted once the result is in
// the output register and not stalled; a scan reads one entry per cycle on the RAM port.
// Reset (synchronous, active low) empties the stack and drops any pending result;
// entry RAM is not cleared.
`default_nettype none

module stack_with_sum_min_max_core import sstk_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_cmd i_command,
    input  wire t_word i_value,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_result   o_result,
    output t_status   o_status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    sstk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_in_stall  (o_in_stall),
        .o_cmd       (dp_cmd)
    );

    // Storage, accumulator and output register
    sstk_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_value     (i_value),
        .i_out_stall (i_out_stall),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_result    (o_result),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

>>> src/sstk_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sstk_checker import sstk_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    o_in_stall,
    input wire logic    o_out_valid,
    input wire logic    i_out_stall,
    input wire t_result o_result,
    input wire t_status o_status
);

    // stalled output beat holds
    `ASSERT_ON_CLK(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result) && $stable(o_status)),
        "output beat changed while stalled")

    // no new command while the result register is blocked
    `ASSERT_WHEN(a_in_blocked, i_clk, i_rst_n,
        o_out_valid && i_out_stall, o_in_stall,
        "input taken while result blocked")

    // overflow carries a zero result
    `ASSERT_WHEN(a_over_zero, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_OVER), o_result == '0,
        "overflow result not zero")

    // empty status carries zero, or all ones for peek
    `ASSERT_WHEN(a_empty_val, i_clk, i_rst_n,
        o_out_valid && (o_status == ST_EMPTY), (o_result == '0) || (o_result == t_result'(-1)),
        "bad result on empty")

endmodule

bind stack_with_sum_min_max_core sstk_checker u_sstk_checker (.*);

`default_nettype wire
